/* hw/rtl/weo_pkg.sv */
package weo_pkg;

  // Default parameter values
  localparam int CORDIC_STAGES_DEF = 20;
  localparam int POS_FRAC_DEF      = 16;

  // Configuration registers
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_GLITCH_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_METERS_PER_TICK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_PER_TICK = 2'd2;
  localparam logic [15:0] GLITCH_RESET = 16'd50;
  localparam logic [31:0] MPT_RESET = 32'd1436355;
  localparam logic [30:0] TPT_RESET = 31'd1039109;

  // CORDIC start vector (gain compensation) in Q2.30
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  // Multiplier operation codes
  localparam logic [2:0] MOP_TRAVEL = 3'd0;
  localparam logic [2:0] MOP_LO_C   = 3'd1;
  localparam logic [2:0] MOP_HI_C   = 3'd2;
  localparam logic [2:0] MOP_LO_S   = 3'd3;
  localparam logic [2:0] MOP_HI_S   = 3'd4;
  localparam logic [2:0] MOP_TURN   = 3'd5;

  // Controller to datapath commands
  typedef struct packed {
    logic       load;
    logic       first_item;
    logic       cord_init;
    logic       cord_step;
    logic       mul_en;
    logic [2:0] mul_op;
    logic       acc_en;
    logic [2:0] acc_op;
    logic       upd;
    logic       out_load;
  } weo_cmd_t;

  // atan(2^-i) in binary angle units
  function automatic logic [31:0] atan_at(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41721;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

/* hw/rtl/weo_in_if.sv */
interface weo_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_count;
  logic signed [15:0] right_count;

  modport source (output valid, output left_count, output right_count, input ready);
  modport sink (input valid, input left_count, input right_count, output ready);
endinterface

/* hw/rtl/weo_out_if.sv */
interface weo_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] x_position;
  logic signed [31:0] y_position;
  logic [31:0]        heading;
  logic               left_rejected;
  logic               right_rejected;

  modport source (output valid, output x_position, output y_position, output heading,
                  output left_rejected, output right_rejected, input ready);
  modport sink (input valid, input x_position, input y_position, input heading,
                input left_rejected, input right_rejected, output ready);
endinterface

/* hw/rtl/weo_ctrl.sv */
module weo_ctrl #(
  parameter int CORDIC_STAGES = weo_pkg::CORDIC_STAGES_DEF,
  parameter int STG_W = $clog2(CORDIC_STAGES)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output weo_pkg::weo_cmd_t cmd,
  output logic [STG_W-1:0] stage
);
  import weo_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TRAV = 3'd1;
  localparam logic [2:0] S_CORD = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  localparam logic [STG_W-1:0] CNT_LAST = STG_W'(CORDIC_STAGES - 1);
  localparam logic [STG_W-1:0] MUL_LAST = STG_W'(5);

  logic [2:0]       state, state_next;
  logic [STG_W-1:0] cnt, cnt_next;
  logic             first_sample, first_sample_next;
  logic             out_valid_next;
  logic             accept, out_free;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign stage    = cnt;

  // Sequence one item through the datapath
  always_comb begin
    state_next = state;
    cnt_next = cnt;
    first_sample_next = first_sample;
    out_valid_next = out_valid && !out_ready;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          cmd.first_item = first_sample;
          first_sample_next = 1'b0;
          state_next = first_sample ? S_FIN : S_TRAV;
        end
      end
      S_TRAV: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MOP_TRAVEL;
        cmd.cord_init = 1'b1;
        cnt_next = '0;
        state_next = S_CORD;
      end
      S_CORD: begin
        cmd.cord_step = 1'b1;
        cmd.acc_en = (cnt == '0);
        cmd.acc_op = MOP_TRAVEL;
        if (cnt == CNT_LAST) begin
          cnt_next = '0;
          state_next = S_MUL;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_MUL: begin
        cmd.mul_en = (cnt != MUL_LAST);
        cmd.mul_op = 3'(cnt + 1'b1);
        cmd.acc_en = (cnt != '0);
        cmd.acc_op = 3'(cnt);
        if (cnt == MUL_LAST) begin
          cnt_next = '0;
          state_next = S_UPD;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_UPD: begin
        cmd.upd = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        // Hold until the output register is free
        if (out_free) begin
          cmd.out_load = 1'b1;
          out_valid_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      first_sample <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      first_sample <= first_sample_next;
      out_valid <= out_valid_next;
    end
  end

  a_first_skips: assert property (@(posedge clk) disable iff (rst)
    accept && first_sample |=> state == S_FIN)
    else $error("first item did not go straight to output");

  a_cord_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_CORD |-> cnt <= CNT_LAST)
    else $error("CORDIC stage count out of range");

  a_rise_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_FIN)
    else $error("result appeared outside final state");

  a_upd_to_fin: assert property (@(posedge clk) disable iff (rst)
    state == S_UPD |=> state == S_FIN)
    else $error("pose update not followed by output");

endmodule

/* hw/rtl/weo_datapath.sv */
module weo_datapath #(
  parameter int CORDIC_STAGES = weo_pkg::CORDIC_STAGES_DEF,
  parameter int POSITION_FRACTION_BITS = weo_pkg::POS_FRAC_DEF,
  parameter int STG_W = $clog2(CORDIC_STAGES)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [weo_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [weo_pkg::CFG_DATA_W-1:0] cfg_data,
  input  weo_pkg::weo_cmd_t              cmd,
  input  logic [STG_W-1:0]               stage,
  input  logic signed [15:0]             left_count,
  input  logic signed [15:0]             right_count,
  output logic signed [31:0]             x_position,
  output logic signed [31:0]             y_position,
  output logic [31:0]                    heading,
  output logic                           left_rejected,
  output logic                           right_rejected
);
  import weo_pkg::*;

  localparam int ACC_W = 85;
  localparam int SH = 63 - POSITION_FRACTION_BITS;
  localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) <<< (SH - 1);
  localparam logic signed [ACC_W-1:0] PMAX = (ACC_W'(1) <<< 31) - 1;
  localparam logic signed [ACC_W-1:0] PMIN = -(ACC_W'(1) <<< 31);

  // Configuration
  logic [15:0] glitch_limit;
  logic [31:0] meters_per_tick;
  logic [30:0] turn_per_tick;

  // State
  logic signed [15:0] previous_left, previous_right;
  logic signed [31:0] pos_x, pos_y;
  logic [31:0]        angle;
  logic signed [17:0] dsum, ddiff;
  logic               lrej, rrej;

  // CORDIC
  logic signed [33:0] cx, cy;
  logic signed [32:0] cz;
  logic               flip;

  // Multiply and accumulate
  logic signed [25:0]      ma;
  logic signed [33:0]      mb;
  logic signed [59:0]      prod;
  logic signed [50:0]      travel;
  logic signed [ACC_W-1:0] accx, accy;
  logic [31:0]             turn;

  // Count change and glitch reject
  logic signed [16:0] dl, dr, dlz, drz;
  logic [16:0]        dl_abs, dr_abs;
  logic               dl_rej, dr_rej;

  always_comb begin
    dl = {left_count[15], left_count} - {previous_left[15], previous_left};
    dr = {right_count[15], right_count} - {previous_right[15], previous_right};
    dl_abs = dl[16] ? 17'(-dl) : 17'(dl);
    dr_abs = dr[16] ? 17'(-dr) : 17'(dr);
    dl_rej = dl_abs > {1'b0, glitch_limit};
    dr_rej = dr_abs > {1'b0, glitch_limit};
    dlz = dl_rej ? '0 : dl;
    drz = dr_rej ? '0 : dr;
  end

  // Write configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      glitch_limit <= GLITCH_RESET;
      meters_per_tick <= MPT_RESET;
      turn_per_tick <= TPT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GLITCH_LIMIT:    glitch_limit <= cfg_data[15:0];
        REG_METERS_PER_TICK: meters_per_tick <= cfg_data[31:0];
        REG_TURN_PER_TICK:   turn_per_tick <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // Latch the item and its count changes
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_left <= '0;
      previous_right <= '0;
    end else if (cmd.load) begin
      previous_left <= left_count;
      previous_right <= right_count;
    end
  end

  // The first item only stores its readings, so its flags stay clear
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dsum <= 18'({dlz[16], dlz} + {drz[16], drz});
      ddiff <= 18'({drz[16], drz} - {dlz[16], dlz});
      lrej <= dl_rej && !cmd.first_item;
      rrej <= dr_rej && !cmd.first_item;
    end
  end

  // Iterative CORDIC, one stage per cycle
  logic [31:0]        fold;
  logic signed [33:0] xs, ys;
  logic signed [32:0] at;

  always_comb begin
    fold = (angle[31] ^ angle[30]) ? {~angle[31], angle[30:0]} : angle;
    xs = cx >>> stage;
    ys = cy >>> stage;
    at = 33'(atan_at(5'(stage)));
  end

  always_ff @(posedge clk) begin
    if (cmd.cord_init) begin
      cx <= CORDIC_GAIN;
      cy <= '0;
      cz <= {fold[31], fold};
      flip <= angle[31] ^ angle[30];
    end else if (cmd.cord_step) begin
      if (!cz[32]) begin
        cx <= cx - ys;
        cy <= cy + xs;
        cz <= cz - at;
      end else begin
        cx <= cx + ys;
        cy <= cy - xs;
        cz <= cz + at;
      end
    end
  end

  // Shared multiplier operand select
  logic signed [33:0] cosv, sinv;

  always_comb begin
    cosv = flip ? -cx : cx;
    sinv = flip ? -cy : cy;
    ma = '0;
    mb = '0;
    case (cmd.mul_op)
      MOP_TRAVEL: begin
        ma = 26'(dsum);
        mb = {2'b00, meters_per_tick};
      end
      MOP_LO_C: begin
        ma = {1'b0, travel[24:0]};
        mb = cosv;
      end
      MOP_HI_C: begin
        ma = travel[50:25];
        mb = cosv;
      end
      MOP_LO_S: begin
        ma = {1'b0, travel[24:0]};
        mb = sinv;
      end
      MOP_HI_S: begin
        ma = travel[50:25];
        mb = sinv;
      end
      MOP_TURN: begin
        ma = 26'(ddiff);
        mb = {3'b000, turn_per_tick};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= ma * mb;
    end
  end

  // Accumulate partial products
  logic signed [ACC_W-1:0] pext;
  assign pext = {{(ACC_W-60){prod[59]}}, prod};

  always_ff @(posedge clk) begin
    if (cmd.acc_en) begin
      case (cmd.acc_op)
        MOP_TRAVEL: travel <= prod[50:0];
        MOP_LO_C:   accx <= pext;
        MOP_HI_C:   accx <= accx + (pext <<< 25);
        MOP_LO_S:   accy <= pext;
        MOP_HI_S:   accy <= accy + (pext <<< 25);
        MOP_TURN:   turn <= prod[31:0];
        default: ;
      endcase
    end
  end

  // Round, add and saturate the pose
  logic signed [ACC_W-1:0] dx, dy, sx, sy;

  always_comb begin
    dx = (accx + RND) >>> SH;
    dy = (accy + RND) >>> SH;
    sx = {{(ACC_W-32){pos_x[31]}}, pos_x} + dx;
    sy = {{(ACC_W-32){pos_y[31]}}, pos_y} + dy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= '0;
      pos_y <= '0;
      angle <= '0;
    end else if (cmd.upd) begin
      pos_x <= (sx > PMAX) ? 32'sh7FFFFFFF : (sx < PMIN) ? 32'sh80000000 : 32'(sx);
      pos_y <= (sy > PMAX) ? 32'sh7FFFFFFF : (sy < PMIN) ? 32'sh80000000 : 32'(sy);
      angle <= angle + turn;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      x_position <= pos_x;
      y_position <= pos_y;
      heading <= angle;
      left_rejected <= lrej;
      right_rejected <= rrej;
    end
  end

endmodule

/* hw/rtl/wheel_encoder_odometry.sv */
// Dead-reckoning odometry for a differential-drive robot.
// in_ch carries one pair of signed 16-bit encoder readings per item; out_ch
// carries x and y (signed, saturating, POSITION_FRACTION_BITS fraction bits),
// the binary-angle heading and two reject flags, one result per input item.
// The configuration port (cfg_we, cfg_index, cfg_data) writes glitch_limit
// (0), meters_per_tick (1) and turn_per_tick (2); write only while idle.
// The first item after reset only stores the readings: it goes straight to
// the final step; its result has the pose unchanged and both flags clear.
// Every later item runs from accept to result through the travel multiply,
// the iterative CORDIC (one stage a cycle), the steps on the one shared
// multiplier, used six times per item, the pose update and the final step.
// One item is in flight at a time; in_ch.ready is high whenever no item is
// being worked on, so a new item is taken only after the last one is done.
// The result sits in an output register; if the receiver stalls, the next
// item is still accepted and computed, and it waits in its final step until
// the output register is taken.
// Synchronous reset restores the register defaults, clears the pose and arms
// the first-item case.
module wheel_encoder_odometry #(
  parameter int CORDIC_STAGES = weo_pkg::CORDIC_STAGES_DEF,
  parameter int POSITION_FRACTION_BITS = weo_pkg::POS_FRAC_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [weo_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [weo_pkg::CFG_DATA_W-1:0] cfg_data,
  weo_in_if.sink                         in_ch,
  weo_out_if.source                      out_ch
);
  import weo_pkg::*;

  localparam int STG_W = $clog2(CORDIC_STAGES);

  weo_cmd_t         cmd;
  logic [STG_W-1:0] stage;

  weo_ctrl #(
    .CORDIC_STAGES(CORDIC_STAGES),
    .STG_W(STG_W)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .cmd(cmd),
    .stage(stage)
  );

  weo_datapath #(
    .CORDIC_STAGES(CORDIC_STAGES),
    .POSITION_FRACTION_BITS(POSITION_FRACTION_BITS),
    .STG_W(STG_W)
  ) u_dp (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cmd(cmd),
    .stage(stage),
    .left_count(in_ch.left_count),
    .right_count(in_ch.right_count),
    .x_position(out_ch.x_position),
    .y_position(out_ch.y_position),
    .heading(out_ch.heading),
    .left_rejected(out_ch.left_rejected),
    .right_rejected(out_ch.right_rejected)
  );

endmodule
